FILE: hw/rtl/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared widths, character codes and the command word passed from the
// front end to the back end of the text terminal writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_AT_RESET = 8'd78;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // command queue depth, a power of two
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CHAR     = 2'd0;
  localparam kind_t KIND_NEWLINE  = 2'd1;
  localparam kind_t KIND_READ     = 2'd2;
  localparam kind_t KIND_READ_OOR = 2'd3;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

endpackage

FILE: hw/rtl/ttcw_ram.sv
// ----------------------------------------------------------------------------
// ttcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ttcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ttcw_front.sv
// ----------------------------------------------------------------------------
// ttcw_front
// Accepts input words, classifies them (character, newline, read, read
// outside the screen) and holds them in a short command queue.
// ----------------------------------------------------------------------------
module ttcw_front #(
  parameter int unsigned COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_operation,
  input  logic [ttcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [ttcw_pkg::ROW_W-1:0]  in_read_row,
  input  logic [ttcw_pkg::COL_W-1:0]  in_read_col,
  input  logic                        clearing,
  output logic                        q_valid,
  output ttcw_pkg::cmd_t              q_cmd,
  input  logic                        q_pop
);

  localparam int unsigned DEPTH = ttcw_pkg::CMDQ_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  ttcw_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  ttcw_pkg::cmd_t  cmd_in;
  logic            accept;
  logic            do_pop;

  always_comb begin
    cmd_in.char_code = in_char_code;
    cmd_in.row       = in_read_row;
    cmd_in.col       = in_read_col;
    if (in_operation == ttcw_pkg::OP_READ) begin
      if ((32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS)) begin
        cmd_in.kind = ttcw_pkg::KIND_READ;
      end else begin
        cmd_in.kind = ttcw_pkg::KIND_READ_OOR;
      end
    end else if (in_char_code == ttcw_pkg::CHAR_NEWLINE) begin
      cmd_in.kind = ttcw_pkg::KIND_NEWLINE;
    end else begin
      cmd_in.kind = ttcw_pkg::KIND_CHAR;
    end
  end

  assign full    = (count_r == CNTW'(DEPTH)) || clearing;
  assign accept  = push && !full;
  assign q_valid = (count_r != '0);
  assign do_pop  = q_pop && q_valid;
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (accept && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!accept && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH))
    else $error("command queue overfilled");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |=> (count_r == $past(count_r)) || ($past(count_r) != '0))
    else $error("word taken during clearing pass");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(q_pop && q_valid)) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow accepted word");

endmodule

FILE: hw/rtl/ttcw_back.sv
// ----------------------------------------------------------------------------
// ttcw_back
// Carries out queued commands against the cell RAM: writes characters,
// moves the cursor, scrolls by rotating the row base and blanking the old
// top row, reads cells, and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module ttcw_back #(
  parameter int unsigned COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = ttcw_pkg::ROWS_DEFAULT,
  localparam int unsigned CELLS  = ROWS * COLUMNS,
  localparam int unsigned AW     = $clog2(CELLS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ttcw_pkg::COLOR_W-1:0] text_color,
  input  logic                         q_valid,
  input  ttcw_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [ttcw_pkg::CELL_W-1:0]  ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  logic [ttcw_pkg::CELL_W-1:0]  ram_rdata,
  output logic                         empty,
  input  logic                         pop,
  output logic [ttcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [ttcw_pkg::COLOR_W-1:0] out_cell_color,
  output logic [ttcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [ttcw_pkg::COL_W-1:0]   out_cursor_col,
  output logic                         out_did_scroll
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLUMNS);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [ttcw_pkg::CELL_W-1:0] RESET_CELL =
    {ttcw_pkg::COLOR_AT_RESET, ttcw_pkg::CHAR_SPACE};

  logic [2:0]                   state_r, state_nxt;
  logic                         init_r, init_nxt;
  ttcw_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [RW-1:0]                prow_r, prow_nxt;
  logic [RW-1:0]                top_r, top_nxt;
  logic [RW-1:0]                cur_row_r, cur_row_nxt;
  logic [CW-1:0]                cur_col_r, cur_col_nxt;
  logic [AW-1:0]                sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]                sweep_end_r, sweep_end_nxt;
  logic [ttcw_pkg::CELL_W-1:0]  sweep_data_r, sweep_data_nxt;
  logic [ttcw_pkg::CHAR_W-1:0]  pend_char_r, pend_char_nxt;
  logic [ttcw_pkg::COLOR_W-1:0] pend_color_r, pend_color_nxt;
  logic                         pend_scroll_r, pend_scroll_nxt;
  logic                         res_valid_r, res_valid_nxt;
  logic [ttcw_pkg::CHAR_W-1:0]  res_char_r, res_char_nxt;
  logic [ttcw_pkg::COLOR_W-1:0] res_color_r, res_color_nxt;
  logic [ttcw_pkg::ROW_W-1:0]   res_row_r, res_row_nxt;
  logic [ttcw_pkg::COL_W-1:0]   res_col_r, res_col_nxt;
  logic                         res_scroll_r, res_scroll_nxt;

  logic          is_read;
  logic [RW-1:0] row_sel;
  logic [RW:0]   psum;
  logic [CW-1:0] col_sel;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] top_base;
  logic          slot_free;

  assign is_read   = (cmd_r.kind == ttcw_pkg::KIND_READ);
  assign row_sel   = is_read ? RW'(cmd_r.row) : cur_row_r;
  assign psum      = {1'b0, top_r} + {1'b0, row_sel};
  assign col_sel   = is_read ? CW'(cmd_r.col) : cur_col_r;
  assign cell_addr = AW'(prow_r * COLUMNS) + AW'(col_sel);
  assign top_base  = AW'(top_r * COLUMNS);
  assign slot_free = !res_valid_r || pop;

  always_comb begin
    state_nxt       = state_r;
    init_nxt        = init_r;
    cmd_nxt         = cmd_r;
    prow_nxt        = prow_r;
    top_nxt         = top_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_end_nxt   = sweep_end_r;
    sweep_data_nxt  = sweep_data_r;
    pend_char_nxt   = pend_char_r;
    pend_color_nxt  = pend_color_r;
    pend_scroll_nxt = pend_scroll_r;
    res_valid_nxt   = res_valid_r && !pop;
    res_char_nxt    = res_char_r;
    res_color_nxt   = res_color_r;
    res_row_nxt     = res_row_r;
    res_col_nxt     = res_col_r;
    res_scroll_nxt  = res_scroll_r;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cell_addr;
    ram_wdata       = {text_color, cmd_r.char_code};
    ram_re          = 1'b0;
    ram_raddr       = cell_addr;

    case (state_r)
      ST_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = sweep_data_r;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == sweep_end_r) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // old top row is now the blank bottom row
            top_nxt   = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop           = 1'b1;
          cmd_nxt         = q_cmd;
          pend_char_nxt   = '0;
          pend_color_nxt  = '0;
          pend_scroll_nxt = 1'b0;
          state_nxt       = ST_ADDR;
        end
      end
      ST_ADDR: begin
        prow_nxt = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : psum[RW-1:0];
        if (cmd_r.kind == ttcw_pkg::KIND_READ_OOR) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (is_read) begin
          ram_re    = 1'b1;
          state_nxt = ST_RDATA;
        end else begin
          state_nxt = ST_EMIT;
          if ((cmd_r.kind == ttcw_pkg::KIND_CHAR) && (cur_col_r != CW'(COLUMNS - 1))) begin
            ram_we      = 1'b1;
            cur_col_nxt = cur_col_r + 1'b1;
          end else begin
            // newline, or wrap after the last column
            ram_we      = (cmd_r.kind == ttcw_pkg::KIND_CHAR);
            cur_col_nxt = '0;
            if (cur_row_r == RW'(ROWS - 1)) begin
              sweep_addr_nxt  = top_base;
              sweep_end_nxt   = top_base + AW'(COLUMNS - 1);
              sweep_data_nxt  = {text_color, ttcw_pkg::CHAR_SPACE};
              pend_scroll_nxt = 1'b1;
              state_nxt       = ST_SWEEP;
            end else begin
              cur_row_nxt = cur_row_r + 1'b1;
            end
          end
        end
      end
      ST_RDATA: begin
        pend_char_nxt  = ram_rdata[ttcw_pkg::CHAR_W-1:0];
        pend_color_nxt = ram_rdata[ttcw_pkg::CELL_W-1:ttcw_pkg::CHAR_W];
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_valid_nxt  = 1'b1;
          res_char_nxt   = pend_char_r;
          res_color_nxt  = pend_color_r;
          res_row_nxt    = ttcw_pkg::ROW_W'(cur_row_r);
          res_col_nxt    = ttcw_pkg::COL_W'(cur_col_r);
          res_scroll_nxt = pend_scroll_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      init_r       <= 1'b1;
      top_r        <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(CELLS - 1);
      sweep_data_r <= RESET_CELL;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      top_r        <= top_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
      sweep_data_r <= sweep_data_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    prow_r        <= prow_nxt;
    pend_char_r   <= pend_char_nxt;
    pend_color_r  <= pend_color_nxt;
    pend_scroll_r <= pend_scroll_nxt;
    res_char_r    <= res_char_nxt;
    res_color_r   <= res_color_nxt;
    res_row_r     <= res_row_nxt;
    res_col_r     <= res_col_nxt;
    res_scroll_r  <= res_scroll_nxt;
  end

  assign clearing       = init_r;
  assign empty          = !res_valid_r;
  assign out_cell_char  = res_char_r;
  assign out_cell_color = res_color_r;
  assign out_cursor_row = res_row_r;
  assign out_cursor_col = res_col_r;
  assign out_did_scroll = res_scroll_r;

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("cell RAM read and written in one cycle");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (state_r == ST_IDLE) && !init_r))
    else $error("command taken outside idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_col_r) < COLUMNS) && (32'(cur_row_r) < ROWS) && (32'(top_r) < ROWS))
    else $error("cursor or row base out of range");

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && slot_free) |=> res_valid_r)
    else $error("result word lost on emit");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && !init_r) |-> (cur_row_r == RW'(ROWS - 1)) && pend_scroll_r)
    else $error("scroll sweep with cursor off the last row");

endmodule

FILE: hw/rtl/text_terminal_char_writer_core.sv
// ----------------------------------------------------------------------------
// text_terminal_char_writer_core
// Sequence: a put steps the back end through ADDR, ACC and EMIT, a read
// through ADDR, ACC, RDATA and EMIT, a read outside the screen through ADDR
// and EMIT; a put that scrolls adds a SWEEP that blanks one row. EMIT waits
// for a free result slot. The back end finishes one word before it takes the
// next; a 2-word command queue decouples the input side. Reset: synchronous;
// a clearing pass fills the RAM with spaces in the reset colour, and full stays high until it ends.
// ----------------------------------------------------------------------------
module text_terminal_char_writer_core #(
  parameter int unsigned COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ttcw_pkg::COLOR_W-1:0] cfg_wr_data,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_operation,
  input  logic [ttcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [ttcw_pkg::ROW_W-1:0]   in_read_row,
  input  logic [ttcw_pkg::COL_W-1:0]   in_read_col,
  output logic                         empty,
  input  logic                         pop,
  output logic [ttcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [ttcw_pkg::COLOR_W-1:0] out_cell_color,
  output logic [ttcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [ttcw_pkg::COL_W-1:0]   out_cursor_col,
  output logic                         out_did_scroll
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [ttcw_pkg::COLOR_W-1:0] text_color_r, text_color_nxt;
  logic                         clearing;
  logic                         q_valid;
  logic                         q_pop;
  ttcw_pkg::cmd_t               q_cmd;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ttcw_pkg::CELL_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [ttcw_pkg::CELL_W-1:0]  ram_rdata;

  assign text_color_nxt = cfg_wr_en ? cfg_wr_data : text_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= ttcw_pkg::COLOR_AT_RESET;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  ttcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  ttcw_ram #(
    .WIDTH (ttcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_color     (text_color_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .empty          (empty),
    .pop            (pop),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_did_scroll (out_did_scroll)
  );

endmodule
